/* src/slpc_pkg.sv */
// ---------------------------------------------------------------------------
// slpc_pkg: shared constants and helpers for the status LED controller
// Event codes, status codes, colours, pattern timing, and the amber scaler.
// ---------------------------------------------------------------------------
package slpc_pkg;

   // event codes carried in func
   localparam logic [2:0] FUNC_TICK   = 3'd0;
   localparam logic [2:0] FUNC_STATUS = 3'd1;
   localparam logic [2:0] FUNC_RAISE  = 3'd2;
   localparam logic [2:0] FUNC_CLEAR  = 3'd3;
   localparam logic [2:0] FUNC_TEST   = 3'd4;

   // status codes; codes below CODE_FLAG_LIMIT are flags
   localparam logic [2:0] CODE_TRANSIENT  = 3'd0;
   localparam logic [2:0] CODE_IR_FAIL    = 3'd1;
   localparam logic [2:0] CODE_HEAT_FAULT = 3'd2;
   localparam logic [2:0] CODE_COLD       = 3'd3;
   localparam logic [2:0] CODE_HEATING    = 3'd4;
   localparam logic [2:0] CODE_COOLING    = 3'd5;
   localparam logic [2:0] CODE_AT_TARGET  = 3'd6;
   localparam logic [2:0] CODE_NONE       = 3'd7;
   localparam logic [2:0] CODE_FLAG_LIMIT = 3'd3;

   // colours, bytes blue / green / red
   localparam logic [23:0] COL_OFF    = 24'h000000;
   localparam logic [23:0] COL_RED    = 24'h0000FF;
   localparam logic [23:0] COL_GREEN  = 24'h00FF00;
   localparam logic [23:0] COL_BLUE   = 24'hFF0000;
   localparam logic [23:0] COL_AMBER  = 24'h0040FF;
   localparam logic [23:0] COL_PURPLE = 24'hFF00FF;
   localparam logic [23:0] COL_WHITE  = 24'hFFFFFF;

   // pattern timing in ms
   localparam int unsigned TRANSIENT_MS = 190;
   localparam int unsigned SLOW_MS      = 2000;
   localparam int unsigned FAST_MS      = 500;
   localparam int unsigned FAST_HALF_MS = 250;
   localparam int unsigned GAP_MS       = 1000;
   localparam int unsigned SLOW_HALF_MS = 1000;

   // blink counts loaded per error code
   localparam logic [2:0] IR_FAST_COUNT   = 3'd5;
   localparam logic [2:0] IR_SLOW_COUNT   = 3'd3;
   localparam logic [2:0] HEAT_FAST_COUNT = 3'd1;
   localparam logic [2:0] HEAT_SLOW_COUNT = 3'd5;

   // brightness in hundredths
   localparam logic [6:0] FULL_LEVEL = 7'd100;

   // pattern offsets stay below 2^15 ms for any 3-bit blink count
   localparam int unsigned PHASE_W     = 15;
   // half-period boundaries inside the longest slow or fast phase (7 blinks)
   localparam int unsigned PHASE_STEPS = 13;

   // channel*level/100 for the two lit amber channels: reciprocal 5243/2^19
   // is exact for products below 43690
   localparam logic [27:0] RED_RECIP   = 28'd1336965;  // 255 * 5243
   localparam logic [27:0] GREEN_RECIP = 28'd335552;   // 64 * 5243
   localparam int unsigned RECIP_SHIFT = 19;

   // amber scaled to a brightness level (blue channel is dark)
   function automatic logic [23:0] amber_scaled(input logic [6:0] level);
      logic [27:0] red_prod;
      logic [27:0] green_prod;
      red_prod   = 28'(level) * RED_RECIP;
      green_prod = 28'(level) * GREEN_RECIP;
      return {8'h00, green_prod[RECIP_SHIFT +: 8], red_prod[RECIP_SHIFT +: 8]};
   endfunction

   // odd when floor(value / half_ms) is odd; value stays below
   // (PHASE_STEPS + 1) * half_ms, so one compare per half period
   function automatic logic phase_odd(input logic [PHASE_W-1:0] value,
                                      input int unsigned half_ms);
      logic odd;
      odd = 1'b0;
      for (int k = 1; k <= PHASE_STEPS; k++) begin
         odd = odd ^ (value >= PHASE_W'(k * half_ms));
      end
      return odd;
   endfunction

endpackage

/* src/status_led_pattern_controller.sv */
// ---------------------------------------------------------------------------
// status_led_pattern_controller: RGB status LED pattern engine
// Turns status, flag, test and tick events into LED colour updates.
// ---------------------------------------------------------------------------
// One event beat is taken per cycle. A beat lands in an input register, is
// worked in one pass of shallow logic against the display state, and its
// colour (if any) then lands in the result register.
// The result register frees itself whenever its beat is taken, so a full
// stream of events runs at one per cycle; only a stalled, occupied result
// register holds up the input. Ticks give a colour only when the shown colour
// changes or on each heating breath step; test colour always gives one;
// other events give none.
module status_led_pattern_controller (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_func,
   input  logic [2:0]  req_status_code,
   input  logic [6:0]  req_breath_floor,
   input  logic [31:0] req_now_ms,
   input  logic [23:0] req_test_colour,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [23:0] rsp_led_colour
);

   localparam int unsigned PHASE_W_L = slpc_pkg::PHASE_W;

   // input stage
   logic        in_valid_ff, in_valid_in;
   logic [2:0]  in_func_ff;
   logic [2:0]  in_code_ff;
   logic [6:0]  in_floor_ff;
   logic [31:0] in_now_ff;
   logic [23:0] in_test_colour_ff;

   // display state
   logic [2:0]  error_flags_ff, error_flags_in;
   logic [2:0]  shown_code_ff, shown_code_in;
   logic [2:0]  wanted_status_ff, wanted_status_in;
   logic [6:0]  breath_floor_level_ff, breath_floor_level_in;
   logic [31:0] code_start_ms_ff, code_start_ms_in;
   logic [2:0]  fast_blink_count_ff, fast_blink_count_in;
   logic [2:0]  slow_blink_count_ff, slow_blink_count_in;
   logic        red_on_ff, red_on_in;
   logic [6:0]  breath_level_ff, breath_level_in;
   logic        breath_rising_ff, breath_rising_in;

   // result stage
   logic        rsp_valid_ff, rsp_valid_in;
   logic [23:0] rsp_colour_ff, rsp_colour_in;

   logic        work;
   logic        emit;
   logic [23:0] emit_colour;
   logic [2:0]  low_code;
   logic [31:0] elapsed;
   logic [PHASE_W_L-1:0] slow_end, fast_end, gap_end, fast_offset;
   logic        want;

   // handshake: the held beat is worked when the result register can take it
   assign work        = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign in_valid_in = (in_valid_ff && !work) || req_valid;
   assign req_stall   = in_valid_ff && !work;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_led_colour = rsp_colour_ff;

   // lowest raised flag and blink pattern timing
   assign low_code = error_flags_ff[0] ? slpc_pkg::CODE_TRANSIENT :
                     (error_flags_ff[1] ? slpc_pkg::CODE_IR_FAIL :
                                          slpc_pkg::CODE_HEAT_FAULT);
   assign elapsed     = in_now_ff - code_start_ms_ff;
   assign slow_end    = PHASE_W_L'(slow_blink_count_ff) * PHASE_W_L'(slpc_pkg::SLOW_MS);
   assign fast_end    = slow_end +
                        PHASE_W_L'(fast_blink_count_ff) * PHASE_W_L'(slpc_pkg::FAST_MS);
   assign gap_end     = fast_end + PHASE_W_L'(slpc_pkg::GAP_MS);
   assign fast_offset = elapsed[PHASE_W_L-1:0] - slow_end;

   // event processing
   always_comb begin
      error_flags_in        = error_flags_ff;
      shown_code_in         = shown_code_ff;
      wanted_status_in      = wanted_status_ff;
      breath_floor_level_in = breath_floor_level_ff;
      code_start_ms_in      = code_start_ms_ff;
      fast_blink_count_in   = fast_blink_count_ff;
      slow_blink_count_in   = slow_blink_count_ff;
      red_on_in             = red_on_ff;
      breath_level_in       = breath_level_ff;
      breath_rising_in      = breath_rising_ff;
      emit                  = 1'b0;
      emit_colour           = slpc_pkg::COL_OFF;
      want                  = 1'b0;

      case (in_func_ff)
         slpc_pkg::FUNC_TICK: begin
            if (error_flags_ff != 3'b000) begin
               if (low_code != shown_code_ff) begin
                  // new flag takes the display
                  shown_code_in    = low_code;
                  code_start_ms_in = in_now_ff;
                  emit             = 1'b1;
                  if (low_code == slpc_pkg::CODE_TRANSIENT) begin
                     emit_colour = slpc_pkg::COL_PURPLE;
                  end else begin
                     error_flags_in = error_flags_ff & 3'b110;
                     red_on_in      = 1'b1;
                     emit_colour    = slpc_pkg::COL_RED;
                     if (low_code == slpc_pkg::CODE_IR_FAIL) begin
                        fast_blink_count_in = slpc_pkg::IR_FAST_COUNT;
                        slow_blink_count_in = slpc_pkg::IR_SLOW_COUNT;
                     end else begin
                        fast_blink_count_in = slpc_pkg::HEAT_FAST_COUNT;
                        slow_blink_count_in = slpc_pkg::HEAT_SLOW_COUNT;
                     end
                  end
               end else if (shown_code_ff == slpc_pkg::CODE_TRANSIENT) begin
                  // purple holds until its time is up
                  if (elapsed >= 32'(slpc_pkg::TRANSIENT_MS)) begin
                     error_flags_in = error_flags_ff & 3'b110;
                  end
               end else begin
                  // slow blinks, fast blinks, dark gap, repeat
                  if (elapsed < 32'(slow_end)) begin
                     want = !slpc_pkg::phase_odd(elapsed[PHASE_W_L-1:0],
                                                 slpc_pkg::SLOW_HALF_MS);
                  end else if (elapsed < 32'(fast_end)) begin
                     want = !slpc_pkg::phase_odd(fast_offset, slpc_pkg::FAST_HALF_MS);
                  end else if (elapsed < 32'(gap_end)) begin
                     want = 1'b0;
                  end else begin
                     code_start_ms_in = in_now_ff;
                     want             = 1'b1;
                  end
                  if (want != red_on_ff) begin
                     red_on_in   = want;
                     emit        = 1'b1;
                     emit_colour = want ? slpc_pkg::COL_RED : slpc_pkg::COL_OFF;
                  end
               end
            end else if (shown_code_ff != wanted_status_ff) begin
               // normal status change
               shown_code_in = wanted_status_ff;
               emit          = 1'b1;
               case (wanted_status_ff)
                  slpc_pkg::CODE_COLD:      emit_colour = slpc_pkg::COL_GREEN;
                  slpc_pkg::CODE_HEATING: begin
                     breath_level_in  = breath_floor_level_ff;
                     breath_rising_in = 1'b1;
                     emit_colour      = slpc_pkg::amber_scaled(breath_floor_level_ff);
                  end
                  slpc_pkg::CODE_COOLING:   emit_colour = slpc_pkg::COL_BLUE;
                  slpc_pkg::CODE_AT_TARGET: emit_colour = slpc_pkg::COL_AMBER;
                  default:                  emit_colour = slpc_pkg::COL_WHITE;
               endcase
            end else if (shown_code_ff == slpc_pkg::CODE_HEATING) begin
               // one breathing step
               if (breath_rising_ff && breath_level_ff < slpc_pkg::FULL_LEVEL) begin
                  breath_level_in = breath_level_ff + 7'd1;
               end else if (breath_level_ff > breath_floor_level_ff) begin
                  breath_level_in  = breath_level_ff - 7'd1;
                  breath_rising_in = 1'b0;
               end else begin
                  breath_level_in  = (breath_floor_level_ff >= slpc_pkg::FULL_LEVEL) ?
                                     slpc_pkg::FULL_LEVEL : breath_floor_level_ff + 7'd1;
                  breath_rising_in = 1'b1;
               end
               emit        = 1'b1;
               emit_colour = slpc_pkg::amber_scaled(breath_level_in);
            end
         end
         slpc_pkg::FUNC_STATUS: begin
            wanted_status_in      = in_code_ff;
            breath_floor_level_in = (in_floor_ff > slpc_pkg::FULL_LEVEL) ?
                                    slpc_pkg::FULL_LEVEL : in_floor_ff;
         end
         slpc_pkg::FUNC_RAISE: begin
            if (in_code_ff < slpc_pkg::CODE_FLAG_LIMIT) begin
               error_flags_in = error_flags_ff | (3'b001 << in_code_ff);
            end
         end
         slpc_pkg::FUNC_CLEAR: begin
            if (in_code_ff < slpc_pkg::CODE_FLAG_LIMIT) begin
               error_flags_in = error_flags_ff & ~(3'b001 << in_code_ff);
            end
         end
         slpc_pkg::FUNC_TEST: begin
            emit        = 1'b1;
            emit_colour = in_test_colour_ff;
         end
         default: begin
         end
      endcase
   end

   // result register next value
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_colour_in = rsp_colour_ff;
      if (work && emit) begin
         rsp_valid_in  = 1'b1;
         rsp_colour_in = emit_colour;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff           <= 1'b0;
         rsp_valid_ff          <= 1'b0;
         error_flags_ff        <= 3'b000;
         shown_code_ff         <= slpc_pkg::CODE_NONE;
         wanted_status_ff      <= slpc_pkg::CODE_NONE;
         breath_floor_level_ff <= 7'd0;
         code_start_ms_ff      <= 32'd0;
         fast_blink_count_ff   <= 3'd0;
         slow_blink_count_ff   <= 3'd0;
         red_on_ff             <= 1'b0;
         breath_level_ff       <= 7'd0;
         breath_rising_ff      <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (work) begin
            error_flags_ff        <= error_flags_in;
            shown_code_ff         <= shown_code_in;
            wanted_status_ff      <= wanted_status_in;
            breath_floor_level_ff <= breath_floor_level_in;
            code_start_ms_ff      <= code_start_ms_in;
            fast_blink_count_ff   <= fast_blink_count_in;
            slow_blink_count_ff   <= slow_blink_count_in;
            red_on_ff             <= red_on_in;
            breath_level_ff       <= breath_level_in;
            breath_rising_ff      <= breath_rising_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_func_ff        <= req_func;
         in_code_ff        <= req_status_code;
         in_floor_ff       <= req_breath_floor;
         in_now_ff         <= req_now_ms;
         in_test_colour_ff <= req_test_colour;
      end
      rsp_colour_ff <= rsp_colour_in;
   end

   // an empty input stage never pushes back
   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> !req_stall)
      else $error("input stalled while input stage empty");

   // a worked test colour beat comes out next cycle unchanged
   a_test_colour_out: assert property (@(posedge clock) disable iff (reset)
      (work && in_func_ff == slpc_pkg::FUNC_TEST) |=>
         (rsp_valid_ff && rsp_colour_ff == $past(in_test_colour_ff)))
      else $error("test colour beat lost or altered");

   // brightness levels stay within full scale
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      breath_level_ff <= slpc_pkg::FULL_LEVEL &&
      breath_floor_level_ff <= slpc_pkg::FULL_LEVEL)
      else $error("brightness level above full scale");

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: testbench for the status LED pattern controller
// Sends tick, status, flag and test colour beats, predicts the LED colour
// updates, and checks each result beat in order against the prediction.
// ---------------------------------------------------------------------------
module tb_top;

   // first of the unused event codes (5..7)
   localparam logic [2:0] FUNC_SPARE_FIRST = 3'd5;
   localparam int unsigned TARGET_EVENTS   = 900;
   localparam int unsigned DRAIN_CYCLES    = 16;
   localparam int unsigned MAX_REPORTS     = 10;
   localparam int unsigned IDLE_PERCENT    = 18;
   localparam int unsigned QUIET_FROM      = 300;
   localparam int unsigned QUIET_TO        = 450;
   localparam int unsigned HOLD_AT         = 600;
   localparam int unsigned HOLD_CYCLES     = 150;

   typedef struct packed {
      logic [2:0]  func;
      logic [2:0]  code;
      logic [6:0]  floor_in;
      logic [31:0] now_ms;
      logic [23:0] colour;
   } led_event_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_func = slpc_pkg::FUNC_TICK;
   logic [2:0]  req_status_code = slpc_pkg::CODE_TRANSIENT;
   logic [6:0]  req_breath_floor = '0;
   logic [31:0] req_now_ms = '0;
   logic [23:0] req_test_colour = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [23:0] rsp_led_colour;

   status_led_pattern_controller dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_status_code  (req_status_code),
      .req_breath_floor (req_breath_floor),
      .req_now_ms       (req_now_ms),
      .req_test_colour  (req_test_colour),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_led_colour   (rsp_led_colour)
   );

   led_event_type pending_events[$];
   logic [23:0] expected_colours[$];
   int unsigned beats_sent = 0;
   int unsigned total_beats = 0;
   int unsigned event_count = 0;
   int unsigned mismatch_count = 0;
   logic [31:0] sim_ms = '0;
   int unsigned hold_left = 0;
   bit          hold_done = 1'b0;
   logic        quiet_span;

   // display state mirrored by the predictor, at reset values
   logic [2:0]  flag_bits   = '0;
   logic [2:0]  showing     = slpc_pkg::CODE_NONE;
   logic [2:0]  want_status = slpc_pkg::CODE_NONE;
   logic [6:0]  floor_lvl   = '0;
   logic [31:0] pattern_t0  = '0;
   logic [2:0]  fast_n      = '0;
   logic [2:0]  slow_n      = '0;
   logic        red_lit     = 1'b0;
   logic [6:0]  breath_lvl  = '0;
   logic        breath_up   = 1'b0;

   assign quiet_span = (beats_sent >= QUIET_FROM) && (beats_sent < QUIET_TO);

   initial begin
      forever #6 clock = ~clock;
   end

   // each 8-bit channel times level in hundredths, truncated
   function automatic logic [23:0] dim_colour(input logic [23:0] c, input logic [6:0] lvl);
      int unsigned b, g, r;
      b = int'(c[23:16]) * int'(lvl) / int'(slpc_pkg::FULL_LEVEL);
      g = int'(c[15:8]) * int'(lvl) / int'(slpc_pkg::FULL_LEVEL);
      r = int'(c[7:0]) * int'(lvl) / int'(slpc_pkg::FULL_LEVEL);
      return {8'(b), 8'(g), 8'(r)};
   endfunction

   // tick: advance flag patterns or the normal status display
   function automatic bit tick_display(input logic [31:0] now, output logic [23:0] colour);
      logic [2:0]  low;
      logic [31:0] el;
      logic [31:0] slow_end;
      logic [31:0] fast_end;
      logic        want;
      colour = slpc_pkg::COL_OFF;
      if (flag_bits != 3'b000) begin
         low = flag_bits[0] ? slpc_pkg::CODE_TRANSIENT :
               (flag_bits[1] ? slpc_pkg::CODE_IR_FAIL : slpc_pkg::CODE_HEAT_FAULT);
         // a new lowest flag takes over the display
         if (low != showing) begin
            showing = low;
            pattern_t0 = now;
            if (low == slpc_pkg::CODE_TRANSIENT) begin
               colour = slpc_pkg::COL_PURPLE;
               return 1'b1;
            end
            flag_bits[0] = 1'b0;
            red_lit = 1'b1;
            if (low == slpc_pkg::CODE_IR_FAIL) begin
               fast_n = slpc_pkg::IR_FAST_COUNT;
               slow_n = slpc_pkg::IR_SLOW_COUNT;
            end else begin
               fast_n = slpc_pkg::HEAT_FAST_COUNT;
               slow_n = slpc_pkg::HEAT_SLOW_COUNT;
            end
            colour = slpc_pkg::COL_RED;
            return 1'b1;
         end
         el = now - pattern_t0;
         // transient expires silently
         if (showing == slpc_pkg::CODE_TRANSIENT) begin
            if (el >= slpc_pkg::TRANSIENT_MS) flag_bits[0] = 1'b0;
            return 1'b0;
         end
         // slow blinks, fast blinks, dark gap, then restart
         slow_end = slow_n * slpc_pkg::SLOW_MS;
         fast_end = slow_end + fast_n * slpc_pkg::FAST_MS;
         if (el < slow_end) begin
            want = ((el / slpc_pkg::SLOW_HALF_MS) % 2) == 0;
         end else if (el < fast_end) begin
            want = (((el - slow_end) / slpc_pkg::FAST_HALF_MS) % 2) == 0;
         end else if (el < fast_end + slpc_pkg::GAP_MS) begin
            want = 1'b0;
         end else begin
            pattern_t0 = now;
            want = 1'b1;
         end
         if (want != red_lit) begin
            red_lit = want;
            colour = want ? slpc_pkg::COL_RED : slpc_pkg::COL_OFF;
            return 1'b1;
         end
         return 1'b0;
      end
      // normal status changed
      if (showing != want_status) begin
         showing = want_status;
         case (showing)
            slpc_pkg::CODE_COLD: colour = slpc_pkg::COL_GREEN;
            slpc_pkg::CODE_HEATING: begin
               breath_lvl = floor_lvl;
               breath_up = 1'b1;
               colour = dim_colour(slpc_pkg::COL_AMBER, breath_lvl);
            end
            slpc_pkg::CODE_COOLING: colour = slpc_pkg::COL_BLUE;
            slpc_pkg::CODE_AT_TARGET: colour = slpc_pkg::COL_AMBER;
            default: colour = slpc_pkg::COL_WHITE;
         endcase
         return 1'b1;
      end
      // heating breathes one hundredth per tick
      if (showing == slpc_pkg::CODE_HEATING) begin
         if (breath_up && (breath_lvl + 1 <= slpc_pkg::FULL_LEVEL)) begin
            breath_lvl = breath_lvl + 1'b1;
         end else if ((breath_lvl >= 1) && (breath_lvl - 1 >= floor_lvl)) begin
            breath_lvl = breath_lvl - 1'b1;
            breath_up = 1'b0;
         end else begin
            breath_lvl = (floor_lvl + 1 > slpc_pkg::FULL_LEVEL) ?
                         slpc_pkg::FULL_LEVEL : floor_lvl + 1'b1;
            breath_up = 1'b1;
         end
         colour = dim_colour(slpc_pkg::COL_AMBER, breath_lvl);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // one accepted event beat: update state, return whether a colour follows
   function automatic bit step_display(input led_event_type ev, output logic [23:0] colour);
      colour = slpc_pkg::COL_OFF;
      case (ev.func)
         slpc_pkg::FUNC_TICK: return tick_display(ev.now_ms, colour);
         slpc_pkg::FUNC_STATUS: begin
            want_status = ev.code;
            floor_lvl = (ev.floor_in > slpc_pkg::FULL_LEVEL) ?
                        slpc_pkg::FULL_LEVEL : ev.floor_in;
         end
         slpc_pkg::FUNC_RAISE:
            if (ev.code < slpc_pkg::CODE_FLAG_LIMIT) flag_bits[ev.code] = 1'b1;
         slpc_pkg::FUNC_CLEAR:
            if (ev.code < slpc_pkg::CODE_FLAG_LIMIT) flag_bits[ev.code] = 1'b0;
         slpc_pkg::FUNC_TEST: begin
            colour = ev.colour;
            return 1'b1;
         end
         default: ;
      endcase
      return 1'b0;
   endfunction

   task automatic add_event(input logic [2:0] func, input logic [2:0] code,
                            input logic [6:0] floor_in, input logic [31:0] now,
                            input logic [23:0] colour);
      led_event_type ev;
      ev.func = func;
      ev.code = code;
      ev.floor_in = floor_in;
      ev.now_ms = now;
      ev.colour = colour;
      pending_events.push_back(ev);
      if (func <= slpc_pkg::FUNC_TEST) event_count++;
   endtask

   // beat with random filler in the floor, time and colour fields
   task automatic add_random(input logic [2:0] func, input logic [2:0] code);
      add_event(func, code, 7'($urandom_range(0, 127)), $urandom,
                24'($urandom_range(0, 24'hFFFFFF)));
   endtask

   task automatic add_tick(input logic [31:0] now);
      add_event(slpc_pkg::FUNC_TICK, 3'($urandom_range(0, 7)), 7'($urandom_range(0, 127)),
                now, 24'($urandom_range(0, 24'hFFFFFF)));
   endtask

   // mostly short steps, now and then a jump anywhere in the 32-bit range
   function automatic logic [31:0] advance_ms();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 2) sim_ms = sim_ms + $urandom;
      else if (pick < 30) sim_ms = sim_ms + $urandom_range(0, 50);
      else sim_ms = sim_ms + $urandom_range(1, 400);
      return sim_ms;
   endfunction

   // sender: offers pending beats, predicts each accepted one
   always @(posedge clock) begin
      led_event_type ev;
      logic [23:0] colour;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            ev = {req_func, req_status_code, req_breath_floor, req_now_ms, req_test_colour};
            if (step_display(ev, colour)) expected_colours.push_back(colour);
            beats_sent <= beats_sent + 1;
         end
         if (!req_valid || !req_stall) begin
            if ((pending_events.size() > 0) &&
                (quiet_span || ($urandom_range(0, 99) >= IDLE_PERCENT))) begin
               ev = pending_events.pop_front();
               req_func <= ev.func;
               req_status_code <= ev.code;
               req_breath_floor <= ev.floor_in;
               req_now_ms <= ev.now_ms;
               req_test_colour <= ev.colour;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall: random, quiet stretch, and one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && (beats_sent >= HOLD_AT)) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (quiet_span) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < IDLE_PERCENT);
      end
   end

   // result checker
   always @(posedge clock) begin
      logic [23:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_colours.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("[%0t] unexpected led colour beat: got %06h", $realtime,
                        rsp_led_colour);
         end else begin
            want = expected_colours.pop_front();
            if (rsp_led_colour !== want) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("[%0t] led colour mismatch: expected %06h got %06h", $realtime,
                           want, rsp_led_colour);
            end
         end
      end
   end

   initial begin
      int unsigned pick;
      int unsigned run;
      logic [2:0]  code;

      // directed: extremes, every event, the special cases
      add_event(slpc_pkg::FUNC_TEST, slpc_pkg::CODE_NONE, 7'd127, 32'hFFFF_FFFF, 24'h000000);
      add_event(slpc_pkg::FUNC_TEST, slpc_pkg::CODE_TRANSIENT, 7'd0, 32'h0, 24'hFFFFFF);
      add_random(FUNC_SPARE_FIRST, slpc_pkg::CODE_AT_TARGET);
      // raise of a non-flag code is ignored
      add_random(slpc_pkg::FUNC_RAISE, slpc_pkg::CODE_COLD);
      add_random(slpc_pkg::FUNC_RAISE, slpc_pkg::CODE_NONE);
      // unknown normal status shows white; floor above full saturates
      add_event(slpc_pkg::FUNC_STATUS, slpc_pkg::CODE_TRANSIENT, 7'd127, $urandom, 24'h123456);
      add_tick(32'd10);
      add_event(slpc_pkg::FUNC_STATUS, slpc_pkg::CODE_HEATING, 7'd127, $urandom, 24'h654321);
      add_tick(32'd20);
      add_tick(32'd30);
      // transient across the 32-bit time wrap
      add_random(slpc_pkg::FUNC_RAISE, slpc_pkg::CODE_TRANSIENT);
      add_tick(32'hFFFF_FF00);
      add_tick(32'h0000_0010);
      add_tick(32'h0000_0020);
      // two errors, lowest served first
      add_random(slpc_pkg::FUNC_RAISE, slpc_pkg::CODE_IR_FAIL);
      add_random(slpc_pkg::FUNC_RAISE, slpc_pkg::CODE_HEAT_FAULT);
      add_tick(32'h0000_0030);
      add_random(slpc_pkg::FUNC_CLEAR, slpc_pkg::CODE_IR_FAIL);
      add_tick(32'h0000_0040);
      add_random(slpc_pkg::FUNC_CLEAR, slpc_pkg::CODE_HEAT_FAULT);
      add_tick(32'h0000_0050);
      add_event(slpc_pkg::FUNC_STATUS, slpc_pkg::CODE_COLD, 7'd0, $urandom, 24'h0);
      add_tick(32'h0000_0060);
      add_event(slpc_pkg::FUNC_STATUS, slpc_pkg::CODE_AT_TARGET, 7'd50, $urandom, 24'h0);
      add_tick(32'h0000_0070);

      // random: mostly tick runs, with error and transient episodes
      sim_ms = ($urandom_range(0, 1) == 0) ? $urandom : 32'hFFFF_0000;
      while (event_count < TARGET_EVENTS) begin
         pick = $urandom_range(0, 99);
         if (pick < 4) begin
            // error episode of 30 to 90 ticks, which may reach fast blinks and the gap
            code = 3'($urandom_range(slpc_pkg::CODE_IR_FAIL, slpc_pkg::CODE_HEAT_FAULT));
            add_random(slpc_pkg::FUNC_RAISE, code);
            run = $urandom_range(30, 90);
            repeat (run) begin
               sim_ms = sim_ms + $urandom_range(40, 300);
               add_tick(sim_ms);
            end
            if ($urandom_range(0, 1) == 1) add_random(slpc_pkg::FUNC_CLEAR, code);
         end else if (pick < 8) begin
            // transient episode
            add_random(slpc_pkg::FUNC_RAISE, slpc_pkg::CODE_TRANSIENT);
            run = $urandom_range(3, 10);
            repeat (run) begin
               sim_ms = sim_ms + $urandom_range(10, 80);
               add_tick(sim_ms);
            end
         end else if (pick < 55) begin
            run = $urandom_range(1, 6);
            repeat (run) add_tick(advance_ms());
         end else if (pick < 68) begin
            code = ($urandom_range(0, 3) != 0) ?
                   3'($urandom_range(slpc_pkg::CODE_COLD, slpc_pkg::CODE_AT_TARGET)) :
                   3'($urandom_range(0, 7));
            add_random(slpc_pkg::FUNC_STATUS, code);
         end else if (pick < 74) begin
            add_random(slpc_pkg::FUNC_RAISE, 3'($urandom_range(0, 7)));
         end else if (pick < 80) begin
            add_random(slpc_pkg::FUNC_CLEAR, 3'($urandom_range(0, 7)));
         end else if (pick < 95) begin
            add_random(slpc_pkg::FUNC_TEST, 3'($urandom_range(0, 7)));
         end else begin
            add_random(3'($urandom_range(FUNC_SPARE_FIRST, 7)), 3'($urandom_range(0, 7)));
         end
      end
      total_beats = pending_events.size();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (beats_sent != total_beats) @(posedge clock);
      while (expected_colours.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
